// File: rtl/mersenne_twister_prng_macros.svh
// assertion helpers for the prng block
`ifndef MERSENNE_TWISTER_PRNG_MACROS_SVH
`define MERSENNE_TWISTER_PRNG_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MTP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtp assertion failed");

// next-cycle implication
`define MTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtp assertion failed");

`else

`define MTP_ASSERT_IMPL(label, ante, cons)
`define MTP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/mtp_pkg.sv
package mtp_pkg;

    localparam int DEF_STATE_WORDS  = 624;
    localparam int DEF_TWIST_OFFSET = 120;
    localparam int WORD_W           = 32;

    localparam logic [WORD_W-1:0] TWIST_XOR = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] LCG_MULT  = 32'd69069;
    localparam logic [WORD_W-1:0] LCG_INC   = 32'd1;
    localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc6_0000;

    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_HI,
        ST_SEED_LO,
        ST_REGEN_PRIME,
        ST_REGEN_LOAD,
        ST_TW_READ,
        ST_TW_WRITE,
        ST_DRAW_START,
        ST_DRAW_WAIT
    } state_t;

    typedef struct packed {
        logic seed_load;
        logic seed_hi;
        logic seed_write;
        logic idx_clear;
        logic idx_inc;
        logic rd_idx;
        logic rd_twist;
        logic cur_load;
        logic tw_write;
        logic pos_clear;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic seeded;
        logic pos_full;
        logic idx_last;
        logic out_free;
    } status_t;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
        logic [WORD_W-1:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// File: rtl/mtp_ctrl.sv
module mtp_ctrl
    import mtp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_opcode,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   draw_pend_reg;
    logic   draw_pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            draw_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            draw_pend_reg <= draw_pend_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        draw_pend_next = draw_pend_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_opcode == OP_RESEED)
                    begin
                        cmd.seed_load = 1'b1;
                        state_next    = ST_SEED_HI;
                    end
                    else
                    begin
                        state_next = ST_DRAW_START;
                    end
                end
            end
            ST_SEED_HI:
            begin
                cmd.seed_hi = 1'b1;
                state_next  = ST_SEED_LO;
            end
            ST_SEED_LO:
            begin
                cmd.seed_write = 1'b1;
                if (status.idx_last)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = ST_REGEN_PRIME;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SEED_HI;
                end
            end
            ST_REGEN_PRIME:
            begin
                cmd.rd_idx = 1'b1;
                state_next = ST_REGEN_LOAD;
            end
            ST_REGEN_LOAD:
            begin
                cmd.cur_load = 1'b1;
                state_next   = ST_TW_READ;
            end
            ST_TW_READ:
            begin
                cmd.rd_twist = 1'b1;
                state_next   = ST_TW_WRITE;
            end
            ST_TW_WRITE:
            begin
                cmd.tw_write = 1'b1;
                if (status.idx_last)
                begin
                    cmd.pos_clear  = 1'b1;
                    draw_pend_next = 1'b0;
                    state_next     = draw_pend_reg ? ST_DRAW_START : ST_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_TW_READ;
                end
            end
            ST_DRAW_START:
            begin
                if (status.pos_full)
                begin
                    cmd.idx_clear  = 1'b1;
                    draw_pend_next = 1'b1;
                    state_next     = ST_REGEN_PRIME;
                end
                else
                begin
                    state_next = ST_DRAW_WAIT;
                end
            end
            ST_DRAW_WAIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/mtp_dpath.sv
module mtp_dpath
    import mtp_pkg::*;
#(
    parameter int STATE_WORDS  = DEF_STATE_WORDS,
    parameter int TWIST_OFFSET = DEF_TWIST_OFFSET
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WORD_W-1:0] seed_value,
    input  cmd_t              cmd,
    output status_t           status,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_data
);

    `include "mersenne_twister_prng_macros.svh"

    localparam int AW  = $clog2(STATE_WORDS);
    localparam int PW  = $clog2(STATE_WORDS + 1);
    localparam int OFF = TWIST_OFFSET % STATE_WORDS;

    logic [WORD_W-1:0] mem [STATE_WORDS];

    logic [WORD_W-1:0] lcg_reg;
    logic [WORD_W-1:0] lcg_next;
    logic [15:0]       hi_reg;
    logic [15:0]       hi_next;
    logic [AW-1:0]     idx_reg;
    logic [AW-1:0]     idx_next;
    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     pos_next;
    logic              seeded_reg;
    logic              seeded_next;
    logic [WORD_W-1:0] cur_reg;
    logic [WORD_W-1:0] cur_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [WORD_W-1:0] m_data_reg;
    logic [WORD_W-1:0] m_data_next;
    logic [WORD_W-1:0] rd0_reg;
    logic [WORD_W-1:0] rd1_reg;

    logic [WORD_W-1:0] lcg_step;
    logic              idx_last;
    logic [AW-1:0]     nxt_idx;
    logic [AW:0]       src_sum;
    logic [AW-1:0]     src_idx;
    logic [AW-1:0]     ra0;
    logic              we;
    logic [WORD_W-1:0] wd;
    logic [WORD_W-1:0] u_word;
    logic [WORD_W-1:0] tw_new;

    assign lcg_step = lcg_reg * LCG_MULT + LCG_INC;
    assign idx_last = idx_reg == AW'(STATE_WORDS - 1);
    assign nxt_idx  = idx_last ? '0 : idx_reg + AW'(1);
    assign src_sum  = {1'b0, idx_reg} + (AW + 1)'(OFF);
    assign src_idx  = (src_sum >= (AW + 1)'(STATE_WORDS))
                    ? AW'(src_sum - (AW + 1)'(STATE_WORDS))
                    : src_sum[AW-1:0];

    // port 0 reads the draw position unless the twist or prime step needs it
    assign ra0 = cmd.rd_twist ? nxt_idx : (cmd.rd_idx ? idx_reg : pos_reg[AW-1:0]);

    assign u_word = {cur_reg[WORD_W-1], rd0_reg[WORD_W-2:0]};
    assign tw_new = rd1_reg ^ (u_word >> 1) ^ (u_word[0] ? TWIST_XOR : '0);

    assign we = cmd.seed_write | cmd.tw_write;
    assign wd = cmd.seed_write ? {hi_reg, lcg_step[WORD_W-1:16]} : tw_new;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[idx_reg] <= wd;
        end
        rd0_reg <= mem[ra0];
        rd1_reg <= mem[src_idx];
    end

    always_comb
    begin
        lcg_next     = lcg_reg;
        hi_next      = hi_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        seeded_next  = seeded_reg;
        cur_next     = cur_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg & ~m_ready;

        if (cmd.seed_load)
        begin
            lcg_next    = seed_value;
            idx_next    = '0;
            pos_next    = '0;
            seeded_next = 1'b1;
        end
        if (cmd.seed_hi)
        begin
            lcg_next = lcg_step;
            hi_next  = lcg_step[WORD_W-1:16];
        end
        if (cmd.seed_write)
        begin
            lcg_next = lcg_step;
        end
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + AW'(1);
        end
        if (cmd.cur_load | cmd.tw_write)
        begin
            cur_next = rd0_reg;
        end
        if (cmd.pos_clear)
        begin
            pos_next = '0;
        end
        // before any seed the store is unwritten and draws read as zero
        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = seeded_reg ? temper(rd0_reg) : '0;
            if (seeded_reg)
            begin
                pos_next = pos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            pos_reg     <= '0;
            seeded_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            pos_reg     <= pos_next;
            seeded_reg  <= seeded_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lcg_reg    <= lcg_next;
        hi_reg     <= hi_next;
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
    end

    assign status.seeded   = seeded_reg;
    assign status.pos_full = pos_reg == PW'(STATE_WORDS);
    assign status.idx_last = idx_last;
    assign status.out_free = ~m_valid_reg | m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `MTP_ASSERT_IMPL(a_load_free, cmd.out_load, !m_valid_reg || m_ready)
    `MTP_ASSERT_IMPL(a_pos_range, 1'b1, pos_reg <= PW'(STATE_WORDS))
    `MTP_ASSERT_IMPL(a_unseeded_pos, !seeded_reg, pos_reg == '0)
    `MTP_ASSERT_NEXT(a_seed_restart, cmd.seed_load, pos_reg == '0 && seeded_reg && idx_reg == '0)

endmodule

// File: rtl/mersenne_twister_prng.sv
// channel   dir  tdata                     tuser
// s_axis    in   [31:0] seed_value         [0] opcode (0 reseed, 1 draw)
// m_axis    out  [31:0] random_value       none
//
// a draw: accept, state memory read, temper into the output register once it is free
// the draw after each STATE_WORDS seeded draws first regenerates the state
// a reseed: accept, lcg fill with a high and a low half per word, then regeneration
// regeneration runs word by word, a registered read of the next word ahead of each write
// reset needs no clearing pass: draws before the first seed return zero
// a result waiting on m_axis stalls only the next draw, not the next request
module mersenne_twister_prng
    import mtp_pkg::*;
#(
    parameter int STATE_WORDS  = DEF_STATE_WORDS,
    parameter int TWIST_OFFSET = DEF_TWIST_OFFSET
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,   // [31:0] seed_value
    input  logic              s_axis_tuser,   // [0] opcode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [WORD_W-1:0] m_axis_tdata    // [31:0] random_value
);

    cmd_t    cmd;
    status_t status;

    mtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mtp_dpath #(
        .STATE_WORDS  (STATE_WORDS),
        .TWIST_OFFSET (TWIST_OFFSET)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_value (s_axis_tdata),
        .cmd        (cmd),
        .status     (status),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata)
    );

endmodule

// File: sim/tb_top.sv
module tb_top;
    import mtp_pkg::*;

    localparam int N_WORDS        = DEF_STATE_WORDS;
    localparam int T_OFFSET       = DEF_TWIST_OFFSET;
    localparam int RANDOM_ITEMS   = 680;
    localparam int IDLE_LIMIT     = 20000;
    localparam int DRAIN_CYCLES   = 6 * N_WORDS;
    localparam int MAX_REPORTS    = 40;

    localparam logic [WORD_W-1:0] HIGH_BIT  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_MASK  = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] HALF_MASK = 32'hffff_0000;

    typedef struct {
        logic              op;
        logic [WORD_W-1:0] seed;
    } request_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [WORD_W-1:0] s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [WORD_W-1:0] m_axis_tdata;

    request_t          request_q[$];
    logic [WORD_W-1:0] expected_words[$];

    // generator mirror
    logic [WORD_W-1:0] twist_state [N_WORDS];
    logic [WORD_W-1:0] tempered_out [N_WORDS];
    int                read_pos;

    int errors;
    int n_reseeds;
    int n_draws;
    int n_regens;
    int n_checked;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int stall_mode;
    int mode_cycles;

    mersenne_twister_prng #(
        .STATE_WORDS  (N_WORDS),
        .TWIST_OFFSET (T_OFFSET)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [WORD_W-1:0] scramble(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic void twist_block();
        logic [WORD_W-1:0] u;
        int                nxt;
        int                src;
        for (int i = 0; i < N_WORDS; i++) begin
            nxt = (i + 1) % N_WORDS;
            src = (i + T_OFFSET) % N_WORDS;
            u = (twist_state[i] & HIGH_BIT) | (twist_state[nxt] & LOW_MASK);
            twist_state[i] = twist_state[src] ^ (u >> 1) ^ (u[0] ? TWIST_XOR : '0);
        end
        for (int i = 0; i < N_WORDS; i++)
            tempered_out[i] = scramble(twist_state[i]);
        read_pos = 0;
    endfunction

    function automatic void apply_request(input request_t req);
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] hi;
        if (req.op == OP_RESEED) begin
            s = req.seed;
            for (int i = 0; i < N_WORDS; i++) begin
                s = LCG_MULT * s + LCG_INC;
                hi = s & HALF_MASK;
                s = LCG_MULT * s + LCG_INC;
                twist_state[i] = hi | ((s & HALF_MASK) >> 16);
            end
            twist_block();
            n_reseeds++;
        end
        else begin
            if (read_pos >= N_WORDS) begin
                twist_block();
                n_regens++;
            end
            expected_words.push_back(tempered_out[read_pos]);
            read_pos++;
            n_draws++;
        end
    endfunction

    function automatic void push_request(input logic op, input logic [WORD_W-1:0] seed);
        request_t req;
        req.op = op;
        req.seed = seed;
        request_q.push_back(req);
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] exp_w,
                                   input logic [WORD_W-1:0] got_w);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch %0s: expected %08h got %08h (result %0d)",
                     what, exp_w, got_w, n_checked);
    endtask

    // request driver with bursts and gaps
    always @(posedge clk) begin
        request_t req;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                req.op = s_axis_tuser;
                req.seed = s_axis_tdata;
                apply_request(req);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (request_q.size() > 0) begin
                    req = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= req.op;
                    s_axis_tdata <= req.seed;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else begin
                        burst_left <= burst_left - 1;
                    end
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own stall pattern
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected random_value", '0, m_axis_tdata);
                else if (expected_words[0] !== m_axis_tdata)
                    report_mismatch("random_value", expected_words.pop_front(), m_axis_tdata);
                else
                    void'(expected_words.pop_front());
                n_checked++;
            end
            if (mode_cycles <= 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_cycles <= $urandom_range(50, 400);
            end
            else begin
                mode_cycles <= mode_cycles - 1;
            end
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (mode_cycles % 3 == 0);
                default: m_axis_tready <= ($urandom_range(0, 9) != 0) ? 1'b0 : 1'b1;
            endcase
        end
    end

    // no progress watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d cycles without progress", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int total;
        int run_len;
        logic [WORD_W-1:0] seed;
        errors = 0;
        n_reseeds = 0;
        n_draws = 0;
        n_regens = 0;
        n_checked = 0;
        idle_cycles = 0;
        burst_left = 1;
        gap_left = 0;
        stall_mode = 0;
        mode_cycles = 0;
        read_pos = 0;
        for (int i = 0; i < N_WORDS; i++) begin
            twist_state[i] = '0;
            tempered_out[i] = '0;
        end

        // draws before any seed, long enough that the mirror regenerates its zero state
        push_request(OP_DRAW, '0);
        push_request(OP_DRAW, '1);
        for (int i = 0; i < N_WORDS + 2; i++)
            push_request(OP_DRAW, $urandom());

        // seed extremes and back-to-back reseeds
        push_request(OP_RESEED, '0);
        for (int i = 0; i < 3; i++)
            push_request(OP_DRAW, '1);
        push_request(OP_RESEED, '1);
        push_request(OP_DRAW, '0);
        push_request(OP_DRAW, '0);
        push_request(OP_RESEED, 32'haaaa_aaaa);
        push_request(OP_RESEED, 32'h5555_5555);
        push_request(OP_DRAW, 32'haaaa_aaaa);
        push_request(OP_DRAW, 32'h5555_5555);
        push_request(OP_RESEED, 32'd1);
        push_request(OP_DRAW, $urandom());
        push_request(OP_RESEED, HIGH_BIT);
        push_request(OP_DRAW, $urandom());
        push_request(OP_RESEED, LOW_MASK);
        push_request(OP_DRAW, $urandom());

        // random reseed and draw runs, the first long enough to wrap the block
        total = 0;
        while (total < RANDOM_ITEMS) begin
            case ($urandom_range(0, 4))
                0: seed = $urandom_range(0, 15);
                1: seed = ~WORD_W'($urandom_range(0, 15));
                default: seed = $urandom();
            endcase
            push_request(OP_RESEED, seed);
            if (total == 0)
                run_len = $urandom_range(N_WORDS + 1, N_WORDS + 20);
            else
                run_len = $urandom_range(0, 40);
            for (int i = 0; i < run_len; i++)
                push_request(OP_DRAW, $urandom());
            total += run_len + 1;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (request_q.size() == 0 && !s_axis_tvalid);
        wait (expected_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d reseeds and %0d draws, %0d regenerations on draw",
                 n_reseeds, n_draws, n_regens);
        $display("%0d results compared, %0d mismatches", n_checked, errors);
        if (errors == 0 && expected_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/mtp_pkg.sv
rtl/mtp_ctrl.sv
rtl/mtp_dpath.sv
rtl/mersenne_twister_prng.sv
sim/tb_top.sv
